@@ src/lpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int unsigned LenWidth   = 24;
   localparam int unsigned CountWidth = 31;
   localparam int unsigned SeqWidth   = 8;
   localparam int unsigned ByteWidth  = 8;

   localparam logic [LenWidth-1:0]   MaxChunk       = 24'hffffff;
   localparam logic [CountWidth-1:0] MaxMessageInit = 31'd67108864;

   typedef enum logic [0:0] {
      CMD_BYTE  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_END_EMPTY = 2'd1,
      KIND_SEQ_ERROR = 2'd2,
      KIND_TOO_LARGE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [ByteWidth-1:0]  payload_byte;
      logic                  last;
      logic [CountWidth-1:0] message_bytes;
      logic [SeqWidth-1:0]   chunk_sequence;
   } rslt_type;

endpackage

@@ src/lpd_front.sv @@
// ----------------------------------------------------------------------------
// lpd_front
// Header parser, sequence and size checker; emits at most one result per byte.
// ----------------------------------------------------------------------------
module lpd_front
   import lpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CountWidth-1:0] csr_wr_data,
   input  logic                  beat_accept,
   input  cmd_type               beat_cmd,
   input  logic [ByteWidth-1:0]  beat_byte,
   output logic                  rslt_valid,
   output rslt_type              rslt
);

   logic [1:0]            hdr_pos_ff, hdr_pos_in;
   logic [LenWidth-1:0]   len_asm_ff, len_asm_in;
   logic [LenWidth-1:0]   left_ff, left_in;
   logic [SeqWidth-1:0]   exp_seq_ff, exp_seq_in;
   logic [CountWidth-1:0] acc_ff, acc_in;
   logic                  full_ff, full_in;
   logic                  in_payload_ff, in_payload_in;
   logic                  failed_ff, failed_in;
   logic [CountWidth-1:0] max_size_ff;
   logic [CountWidth:0]   size_sum;
   logic [CountWidth-1:0] acc_inc;

   assign size_sum = {1'b0, acc_ff} + {{(CountWidth+1-LenWidth){1'b0}}, len_asm_ff};
   assign acc_inc  = acc_ff + {{(CountWidth-1){1'b0}}, 1'b1};

   always_comb begin
      hdr_pos_in    = hdr_pos_ff;
      len_asm_in    = len_asm_ff;
      left_in       = left_ff;
      exp_seq_in    = exp_seq_ff;
      acc_in        = acc_ff;
      full_in       = full_ff;
      in_payload_in = in_payload_ff;
      failed_in     = failed_ff;
      rslt_valid    = 1'b0;
      rslt          = '{kind: KIND_PAYLOAD, payload_byte: '0, last: 1'b0,
                        message_bytes: acc_ff, chunk_sequence: beat_byte};
      if (beat_accept) begin
         if (beat_cmd == CMD_CLEAR) begin
            hdr_pos_in    = '0;
            len_asm_in    = '0;
            left_in       = '0;
            exp_seq_in    = '0;
            acc_in        = '0;
            full_in       = 1'b0;
            in_payload_in = 1'b0;
            failed_in     = 1'b0;
         end else if (!failed_ff) begin
            if (in_payload_ff) begin
               rslt_valid          = 1'b1;
               rslt.payload_byte   = beat_byte;
               rslt.message_bytes  = acc_inc;
               rslt.chunk_sequence = exp_seq_ff - {{(SeqWidth-1){1'b0}}, 1'b1};
               acc_in              = acc_inc;
               left_in             = left_ff - {{(LenWidth-1){1'b0}}, 1'b1};
               if (left_ff == {{(LenWidth-1){1'b0}}, 1'b1}) begin
                  in_payload_in = 1'b0;
                  hdr_pos_in    = '0;
                  if (!full_ff) begin
                     rslt.last = 1'b1;
                     acc_in    = '0;
                  end
               end
            end else if (hdr_pos_ff != 2'd3) begin
               hdr_pos_in = hdr_pos_ff + 2'd1;
               case (hdr_pos_ff)
                  2'd0:    len_asm_in[7:0]   = beat_byte;
                  2'd1:    len_asm_in[15:8]  = beat_byte;
                  default: len_asm_in[23:16] = beat_byte;
               endcase
            end else begin
               hdr_pos_in = '0;
               len_asm_in = '0;
               if (beat_byte != exp_seq_ff) begin
                  failed_in  = 1'b1;
                  rslt_valid = 1'b1;
                  rslt.kind  = KIND_SEQ_ERROR;
               end else begin
                  exp_seq_in = exp_seq_ff + {{(SeqWidth-1){1'b0}}, 1'b1};
                  if (len_asm_ff == '0) begin
                     rslt_valid = 1'b1;
                     rslt.kind  = KIND_END_EMPTY;
                     rslt.last  = 1'b1;
                     acc_in     = '0;
                  end else if (size_sum >= {1'b0, max_size_ff}) begin
                     failed_in  = 1'b1;
                     rslt_valid = 1'b1;
                     rslt.kind  = KIND_TOO_LARGE;
                  end else begin
                     left_in       = len_asm_ff;
                     full_in       = (len_asm_ff == MaxChunk);
                     in_payload_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff    <= '0;
         len_asm_ff    <= '0;
         left_ff       <= '0;
         exp_seq_ff    <= '0;
         acc_ff        <= '0;
         full_ff       <= 1'b0;
         in_payload_ff <= 1'b0;
         failed_ff     <= 1'b0;
         max_size_ff   <= MaxMessageInit;
      end else begin
         hdr_pos_ff    <= hdr_pos_in;
         len_asm_ff    <= len_asm_in;
         left_ff       <= left_in;
         exp_seq_ff    <= exp_seq_in;
         acc_ff        <= acc_in;
         full_ff       <= full_in;
         in_payload_ff <= in_payload_in;
         failed_ff     <= failed_in;
         if (csr_wr_en) begin
            max_size_ff <= csr_wr_data;
         end
      end
   end

endmodule

@@ src/lpd_queue.sv @@
// ----------------------------------------------------------------------------
// lpd_queue
// Small result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module lpd_queue
   import lpd_pkg::*;
#(
   parameter int unsigned Depth = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  rslt_type push_data,
   input  logic     pop,
   output rslt_type pop_data,
   output logic     empty,
   output logic     full
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   rslt_type              mem [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]   cnt_ff;
   logic                  do_push, do_pop;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == FullCnt);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CntWidth'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CntWidth'(1);
         end
      end
   end

endmodule

@@ src/lpd_back.sv @@
// ----------------------------------------------------------------------------
// lpd_back
// Output stage: holds one result beat and packs it onto the result channel.
// ----------------------------------------------------------------------------
module lpd_back
   import lpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  rslt_type    q_data,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic     valid_ff;
   rslt_type out_ff;

   assign q_pop = !q_empty && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff <= q_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {1'b0, out_ff.chunk_sequence, out_ff.message_bytes,
                        out_ff.payload_byte};

endmodule

@@ src/length_prefixed_packet_deframer_top.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_top
// Deframer for length-prefixed, sequence-numbered chunks on a byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte beat per clock and gives at most one result beat
// per byte. Each chunk opens with a 24-bit little-endian length and a sequence
// byte; payload bytes then pass through, and each result is registered first in
// the queue and then in the output register. The result queue of QUEUE_DEPTH
// entries lets the input keep running while the result side stalls; the input
// stalls only once that queue fills.
module length_prefixed_packet_deframer_top
   import lpd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,   // max_message_size
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // data_byte
   input  logic        req_tuser,     // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,     // payload_byte, message_bytes, chunk_sequence
   output logic [1:0]  rsp_tuser,     // kind
   output logic        rsp_tlast
);

   logic     beat_accept;
   logic     rslt_valid;
   rslt_type rslt;
   rslt_type q_data;
   logic     q_empty, q_full, q_pop;

   assign req_tready  = !q_full;
   assign beat_accept = req_tvalid && req_tready;

   lpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .beat_accept (beat_accept),
      .beat_cmd    (cmd_type'(req_tuser)),
      .beat_byte   (req_tdata),
      .rslt_valid  (rslt_valid),
      .rslt        (rslt)
   );

   lpd_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rslt_valid),
      .push_data (rslt),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   lpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed packet deframer. A short table
// of beats covers the plain chunk, the empty chunk, sequence error, error
// hold, clear, the full-length chunk header and the size limit. Random phases
// under several size limits follow: mostly well-formed chunks with random
// payload, mixed with wrong sequence numbers, abandoned chunks and noise.
// Every result beat is compared field by field against a cycle-free predictor
// of the deframer; the sender bursts and pauses, the receiver stalls on its
// own pattern and twice holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;
   import lpd_pkg::*;

   localparam int QuietLimit  = 2000;
   localparam int HoldCycles  = 300;
   localparam int SettleTicks = 8;
   localparam int NumPhases   = 9;
   localparam int BeatGoal    = 950;

   typedef struct {
      bit          is_csr;
      logic [30:0] csr_val;
      cmd_type     cmd;
      logic [7:0]  data;
      bit          pin;
      rslt_type    want;
   } stim_row_type;

   typedef struct {
      bit       on;
      rslt_type r;
   } pinned_rslt_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [30:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // deframer shadow state
   logic [1:0]            p_hdr_pos;
   logic [LenWidth-1:0]   p_len_acc;
   logic [LenWidth-1:0]   p_chunk_left;
   logic [SeqWidth-1:0]   p_next_seq;
   logic [CountWidth-1:0] p_msg_bytes;
   logic                  p_full_chunk;
   logic                  p_in_payload;
   logic                  p_held;
   logic [CountWidth-1:0] p_limit;

   rslt_type        expected_rslts[$];
   pinned_rslt_type pinned_rslts[$];
   stim_row_type    tbl[$];

   bit         next_pin;
   rslt_type   next_want;
   int         burst_left;
   int         beats_live;
   int         mismatches;
   int         quiet_cycles;
   int         hold_off_asked;
   int         hold_off_done;
   logic [7:0] gen_seq;
   bit         gen_failed;

   length_prefixed_packet_deframer_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   initial begin
      p_hdr_pos    = '0;
      p_len_acc    = '0;
      p_chunk_left = '0;
      p_next_seq   = '0;
      p_msg_bytes  = '0;
      p_full_chunk = 1'b0;
      p_in_payload = 1'b0;
      p_held       = 1'b0;
      p_limit      = MaxMessageInit;
   end

   function automatic void drop_parse();
      p_hdr_pos    = '0;
      p_len_acc    = '0;
      p_chunk_left = '0;
      p_msg_bytes  = '0;
      p_full_chunk = 1'b0;
      p_in_payload = 1'b0;
   endfunction

   function automatic bit deframe_byte(input cmd_type cmd, input logic [7:0] b,
                                       output rslt_type r);
      logic [LenWidth-1:0] len;
      r = '0;
      if (cmd == CMD_CLEAR) begin
         p_next_seq = '0;
         p_held     = 1'b0;
         drop_parse();
         return 1'b0;
      end
      if (p_held)
         return 1'b0;
      if (p_in_payload) begin
         p_msg_bytes      = p_msg_bytes + 31'd1;
         p_chunk_left     = p_chunk_left - 24'd1;
         r.kind           = KIND_PAYLOAD;
         r.payload_byte   = b;
         r.message_bytes  = p_msg_bytes;
         r.chunk_sequence = p_next_seq - 8'd1;
         if (p_chunk_left == '0) begin
            p_in_payload = 1'b0;
            p_hdr_pos    = '0;
            if (!p_full_chunk) begin
               r.last      = 1'b1;
               p_msg_bytes = '0;
            end
         end
         return 1'b1;
      end
      if (p_hdr_pos < 2'd3) begin
         p_len_acc = p_len_acc | ({16'd0, b} << (8 * p_hdr_pos));
         p_hdr_pos = p_hdr_pos + 2'd1;
         return 1'b0;
      end
      len              = p_len_acc;
      p_hdr_pos        = '0;
      p_len_acc        = '0;
      r.chunk_sequence = b;
      r.message_bytes  = p_msg_bytes;
      if (b != p_next_seq) begin
         p_held = 1'b1;
         r.kind = KIND_SEQ_ERROR;
         return 1'b1;
      end
      p_next_seq = p_next_seq + 8'd1;
      if (len == '0) begin
         r.kind      = KIND_END_EMPTY;
         r.last      = 1'b1;
         p_msg_bytes = '0;
         return 1'b1;
      end
      if (({1'b0, p_msg_bytes} + {8'd0, len}) >= {1'b0, p_limit}) begin
         p_held = 1'b1;
         r.kind = KIND_TOO_LARGE;
         return 1'b1;
      end
      p_chunk_left = len;
      p_full_chunk = (len == MaxChunk);
      p_in_payload = 1'b1;
      return 1'b0;
   endfunction

   task automatic flag_result(input bit orphan, input rslt_type want, input rslt_type got);
      mismatches++;
      if (mismatches <= 10) begin
         if (orphan)
            $display("unexpected result: kind %0d byte %h last %0d count %0d seq %0d",
                     got.kind, got.payload_byte, got.last, got.message_bytes,
                     got.chunk_sequence);
         else
            $display("result mismatch (exp/act): kind %0d/%0d byte %h/%h last %0d/%0d %s",
                     want.kind, got.kind, want.payload_byte, got.payload_byte,
                     want.last, got.last,
                     $sformatf("count %0d/%0d seq %0d/%0d",
                               want.message_bytes, got.message_bytes,
                               want.chunk_sequence, got.chunk_sequence));
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rslt_type        pred;
      rslt_type        got;
      rslt_type        want;
      bit              has;
      pinned_rslt_type pe;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pe  = pinned_rslts.pop_front();
            has = deframe_byte(cmd_type'(req_tuser), req_tdata, pred);
            if (pe.on)
               expected_rslts.push_back(pe.r);
            else if (has)
               expected_rslts.push_back(pred);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {kind_type'(rsp_tuser), rsp_tdata[7:0], rsp_tlast, rsp_tdata[38:8],
                   rsp_tdata[46:39]};
            if (expected_rslts.size() == 0) begin
               flag_result(1'b1, '0, got);
            end else begin
               want = expected_rslts.pop_front();
               if (got !== want)
                  flag_result(1'b0, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver: own stall pattern, plus long hold-offs on request
   initial begin : receiver
      int mode;
      int span;
      int k;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 80);
         for (k = 0; k < span; k++) begin
            if (hold_off_done != hold_off_asked) begin
               hold_off_done++;
               rsp_tready <= 1'b0;
               repeat (HoldCycles) @(posedge clock);
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ((k % 4) < 2);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_beat(input cmd_type cmd, input logic [7:0] b);
      pinned_rslts.push_back('{on: next_pin, r: next_want});
      next_pin  = 1'b0;
      next_want = '0;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      beats_live++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic drain_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rslts.size() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
   endtask

   task automatic write_limit(input logic [30:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      p_limit = v;
   endtask

   task automatic add_row(input bit is_csr, input logic [30:0] v, input cmd_type c,
                          input logic [7:0] d, input bit pin, input rslt_type w);
      tbl.push_back('{is_csr: is_csr, csr_val: v, cmd: c, data: d, pin: pin, want: w});
   endtask

   task automatic send_header(input logic [23:0] len, input logic [7:0] seq);
      send_beat(CMD_BYTE, len[7:0]);
      send_beat(CMD_BYTE, len[15:8]);
      send_beat(CMD_BYTE, len[23:16]);
      send_beat(CMD_BYTE, seq);
   endtask

   task automatic gen_sequence();
      int          pick;
      int          k;
      int          n;
      logic [23:0] len;
      logic [7:0]  bad_seq;
      if (gen_failed) begin
         n = $urandom_range(0, 4);
         for (k = 0; k < n; k++) send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
         gen_failed = 1'b0;
         gen_seq    = '0;
         send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
         return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
         k   = $urandom_range(0, 19);
         len = (k < 2) ? 24'd0 : (k < 17) ? 24'($urandom_range(1, 16))
                                          : 24'($urandom_range(17, 64));
         send_header(len, gen_seq);
         gen_seq = gen_seq + 8'd1;
         if (len != 0) begin
            if ({7'd0, len} >= p_limit)
               gen_failed = 1'b1;
            else
               for (k = 0; k < len; k++) send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
         end
      end else if (pick < 75) begin
         bad_seq = gen_seq + 8'($urandom_range(1, 255));
         send_header(24'($urandom_range(0, 16)), bad_seq);
         gen_failed = 1'b1;
      end else if (pick < 85) begin
         // abandon a long chunk after a few payload beats
         len = ($urandom_range(0, 2) == 0) ? MaxChunk : (24'($urandom) | 24'd1);
         send_header(len, gen_seq);
         gen_seq = gen_seq + 8'd1;
         if ({7'd0, len} >= p_limit) begin
            gen_failed = 1'b1;
         end else begin
            n = $urandom_range(0, 6);
            for (k = 0; k < n && k < len; k++)
               send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
            gen_seq = '0;
            send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
         end
      end else begin
         // noise or broken header, then resync
         n = $urandom_range(0, 7);
         for (k = 0; k < n; k++) send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
         gen_seq = '0;
         send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : driver
      logic [30:0] limits[NumPhases];
      int i;
      int phase;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_BYTE;
      next_pin       = 1'b0;
      next_want      = '0;
      burst_left     = 0;
      beats_live     = 0;
      mismatches     = 0;
      quiet_cycles   = 0;
      hold_off_asked = 0;
      hold_off_done  = 0;
      gen_seq        = '0;
      gen_failed     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_row(0, 0, CMD_BYTE, 8'h01, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'hab, 1, {KIND_PAYLOAD, 8'hab, 1'b1, 31'd1, 8'd0});
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h01, 1, {KIND_END_EMPTY, 8'h00, 1'b1, 31'd0, 8'd1});
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h07, 1, {KIND_SEQ_ERROR, 8'h00, 1'b0, 31'd0, 8'd7});
      add_row(0, 0, CMD_BYTE, 8'hff, 0, '0);
      add_row(0, 0, CMD_CLEAR, 8'hff, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'hff, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'hff, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'hff, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h5a, 1, {KIND_PAYLOAD, 8'h5a, 1'b0, 31'd1, 8'd0});
      add_row(0, 0, CMD_CLEAR, 8'h00, 0, '0);
      add_row(1, 31'd2, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h02, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 0, '0);
      add_row(0, 0, CMD_BYTE, 8'h00, 1, {KIND_TOO_LARGE, 8'h00, 1'b0, 31'd0, 8'd0});
      add_row(0, 0, CMD_CLEAR, 8'h00, 0, '0);

      for (i = 0; i < tbl.size(); i++) begin
         if (tbl[i].is_csr) begin
            drain_idle();
            write_limit(tbl[i].csr_val);
         end else begin
            next_pin  = tbl[i].pin;
            next_want = tbl[i].want;
            send_beat(tbl[i].cmd, tbl[i].data);
         end
      end

      limits[0] = 31'd1;
      limits[1] = 31'd1073741824;
      limits[2] = 31'($urandom_range(1, 40));
      limits[3] = MaxMessageInit;
      limits[4] = 31'd16777215;
      limits[5] = 31'($urandom_range(1, 32'h3fffffff));
      limits[6] = 31'd16777216;
      limits[7] = 31'($urandom_range(1, 20));
      limits[8] = 31'($urandom & 32'h3fffffff) | 31'd1;
      for (phase = 0; phase < NumPhases; phase++) begin
         drain_idle();
         write_limit(limits[phase]);
         if (phase == 3 || phase == 6)
            hold_off_asked++;
         while (beats_live < BeatGoal * (phase + 1) / NumPhases + tbl.size())
            gen_sequence();
      end
      drain_idle();

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
src/lpd_pkg.sv
src/lpd_front.sv
src/lpd_queue.sv
src/lpd_back.sv
src/length_prefixed_packet_deframer_top.sv
tb/testbench.sv
